### src/brm_pkg.sv
`timescale 1ns / 1ps
// brm_pkg: shared constants, booth digit codes and tree sizing functions
// for the radix-4 booth multiplier. no dependencies.
package brm_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int IN_WIDTH          = 32;
    localparam int OUT_WIDTH         = 64;

    // booth digit codes {y[2i+1], y[2i], y[2i-1]}
    localparam logic [2:0] BD_ZERO_P = 3'b000;
    localparam logic [2:0] BD_P1_A   = 3'b001;
    localparam logic [2:0] BD_P1_B   = 3'b010;
    localparam logic [2:0] BD_P2     = 3'b011;
    localparam logic [2:0] BD_M2     = 3'b100;
    localparam logic [2:0] BD_M1_A   = 3'b101;
    localparam logic [2:0] BD_M1_B   = 3'b110;
    localparam logic [2:0] BD_ZERO_M = 3'b111;

    // rows left after a number of 3:2 levels
    function automatic int csa_count(int n, int levels);
        int c;
        c = n;
        for (int k = 0; k < levels; k++) begin
            c = c - c / 3;
        end
        return c;
    endfunction

    // 3:2 levels needed to bring n rows down to two
    function automatic int csa_levels(int n);
        int c;
        int l;
        c = n;
        l = 0;
        while (c > 2) begin
            c = c - c / 3;
            l++;
        end
        return l;
    endfunction

endpackage

### src/brm_ppgen.sv
`timescale 1ns / 1ps
// brm_ppgen: booth recoding and partial product rows with sign extension
// prevention bits, plus one row of negation carry-ins. uses brm_pkg.
module brm_ppgen #(
    parameter int W = brm_pkg::OPERAND_WIDTH_DEF,
    localparam int ROWS = W / 2 + 1,
    localparam int NPP  = ROWS + 1,
    localparam int PW   = 2 * W
) (
    input  logic [W-1:0]  i_x,
    input  logic [W-1:0]  i_y,
    output logic [PW-1:0] o_rows [NPP]
);

    logic [W:0]    xe;
    logic [W:0]    x2;
    logic [W+2:0]  ye;
    logic [2:0]    dig;
    logic [W:0]    pp;
    logic          neg;
    logic [PW-1:0] negrow;

    always_comb begin
        xe     = {i_x[W-1], i_x};
        x2     = {i_x, 1'b0};
        ye     = {i_y[W-1], i_y[W-1], i_y, 1'b0};
        negrow = '0;
        for (int i = 0; i < ROWS; i++) begin
            dig = ye[2*i +: 3];
            case (dig) inside
                brm_pkg::BD_P1_A, brm_pkg::BD_P1_B: begin
                    pp  = xe;
                    neg = 1'b0;
                end
                brm_pkg::BD_P2: begin
                    pp  = x2;
                    neg = 1'b0;
                end
                brm_pkg::BD_M2: begin
                    pp  = ~x2;
                    neg = 1'b1;
                end
                brm_pkg::BD_M1_A, brm_pkg::BD_M1_B: begin
                    pp  = ~xe;
                    neg = 1'b1;
                end
                default: begin
                    pp  = '0;
                    neg = 1'b0;
                end
            endcase
            if (i == 0) begin
                o_rows[i] = PW'({~pp[W], pp[W], pp[W], pp});
            end else begin
                o_rows[i] = PW'({1'b1, ~pp[W], pp}) << (2 * i);
            end
            negrow[2*i] = neg;
        end
        o_rows[NPP-1] = negrow;
    end

endmodule

### src/brm_csa_tree.sv
`timescale 1ns / 1ps
// brm_csa_tree: a fixed number of carry-save 3:2 levels over PW-bit rows.
// uses brm_pkg for row counts per level.
module brm_csa_tree #(
    parameter int PW     = 64,
    parameter int NUM_IN = 18,
    parameter int LEVELS = 3,
    localparam int NUM_OUT = brm_pkg::csa_count(NUM_IN, LEVELS)
) (
    input  logic [PW-1:0] i_rows [NUM_IN],
    output logic [PW-1:0] o_rows [NUM_OUT]
);

    logic [PW-1:0] lvl [LEVELS+1][NUM_IN];

    for (genvar k = 0; k < NUM_IN; k++) begin : g_in
        assign lvl[0][k] = i_rows[k];
    end

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int C = brm_pkg::csa_count(NUM_IN, l);
        localparam int G = C / 3;
        localparam int R = C - 3 * G;
        for (genvar j = 0; j < G; j++) begin : g_fa
            assign lvl[l+1][2*j]   = lvl[l][3*j] ^ lvl[l][3*j+1] ^ lvl[l][3*j+2];
            assign lvl[l+1][2*j+1] = ((lvl[l][3*j] & lvl[l][3*j+1])
                                    | (lvl[l][3*j] & lvl[l][3*j+2])
                                    | (lvl[l][3*j+1] & lvl[l][3*j+2])) << 1;
        end
        for (genvar r = 0; r < R; r++) begin : g_pass
            assign lvl[l+1][2*G+r] = lvl[l][3*G+r];
        end
        for (genvar k = 2 * G + R; k < NUM_IN; k++) begin : g_zero
            assign lvl[l+1][k] = '0;
        end
    end

    for (genvar k = 0; k < NUM_OUT; k++) begin : g_out
        assign o_rows[k] = lvl[LEVELS][k];
    end

endmodule

### src/booth_radix4_signed_multiplier_unit.sv
`timescale 1ns / 1ps
// booth_radix4_signed_multiplier_unit: pipelined signed radix-4 booth multiplier.
// uses brm_pkg, brm_ppgen and brm_csa_tree.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------
//  in      | i_valid | o_ready | i_multiplicand, i_multiplier
//  out     | o_valid | i_ready | o_product
//
// one operand pair per cycle unless full and stalled; stages: booth rows, two
// halves of the carry-save tree, 2*OPERAND_WIDTH-bit carry-propagate adder
// each stage has its own valid bit; a stage loads when it is empty or the next
// stage moves, so bubbles close up under a stall and no transfer is lost
// reset (synchronous, active low) clears the valid bits only
// operand bits at and above OPERAND_WIDTH are ignored
module booth_radix4_signed_multiplier_unit #(
    parameter int OPERAND_WIDTH = brm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [brm_pkg::IN_WIDTH-1:0]   i_multiplicand,
    input  logic signed [brm_pkg::IN_WIDTH-1:0]   i_multiplier,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [brm_pkg::OUT_WIDTH-1:0]  o_product
);

    localparam int PW      = 2 * OPERAND_WIDTH;
    localparam int NPP     = OPERAND_WIDTH / 2 + 2;
    localparam int LVL_ALL = brm_pkg::csa_levels(NPP);
    localparam int LVL_A   = (LVL_ALL + 1) / 2;
    localparam int LVL_B   = LVL_ALL - LVL_A;
    localparam int NA      = brm_pkg::csa_count(NPP, LVL_A);
    localparam int NB      = brm_pkg::csa_count(NA, LVL_B);

    logic [PW-1:0] w_pp [NPP];
    logic [PW-1:0] w_s2 [NA];
    logic [PW-1:0] w_s3 [NB];
    logic signed [PW-1:0] w_sum;

    logic [PW-1:0] r_pp [NPP];
    logic [PW-1:0] r_s2 [NA];
    logic [PW-1:0] r_s3 [NB];
    logic signed [brm_pkg::OUT_WIDTH-1:0] r_product;
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    brm_ppgen #(
        .W(OPERAND_WIDTH)
    ) u_ppgen (
        .i_x   (i_multiplicand[OPERAND_WIDTH-1:0]),
        .i_y   (i_multiplier[OPERAND_WIDTH-1:0]),
        .o_rows(w_pp)
    );

    brm_csa_tree #(
        .PW    (PW),
        .NUM_IN(NPP),
        .LEVELS(LVL_A)
    ) u_tree_a (
        .i_rows(r_pp),
        .o_rows(w_s2)
    );

    brm_csa_tree #(
        .PW    (PW),
        .NUM_IN(NA),
        .LEVELS(LVL_B)
    ) u_tree_b (
        .i_rows(r_s2),
        .o_rows(w_s3)
    );

    assign w_sum = r_s3[0] + r_s3[1];

    // stall chain
    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_pp <= w_pp;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= w_s2;
        end
        if (w_rdy3 && r_v2) begin
            r_s3 <= w_s3;
        end
        if (w_rdy4 && r_v3) begin
            r_product <= brm_pkg::OUT_WIDTH'(w_sum);
        end
    end

    assign o_ready   = w_rdy1;
    assign o_valid   = r_v4;
    assign o_product = r_product;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3 && !r_v4)
        else $error("pipeline not empty after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted transfer did not enter first stage");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && r_v4)
        else $error("input blocked with a bubble in the pipeline");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_rdy2 |=> r_v2 && r_v3 && r_v4)
        else $error("stalled stage lost its item");

endmodule
